// ===== rtl/rwnlb_pkg.sv =====
// Package for the range window neighbor list builder.
// Holds widths, register indexes and helper functions; no dependencies.
package rwnlb_pkg;

  localparam int MAX_K      = 16;
  localparam int MAX_POINTS = 1048576;

  localparam int IDX_W   = 20;
  localparam int BND_W   = 21;
  localparam int NW_W    = 5;
  localparam int CFG_W   = 21;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W   = $clog2(MAX_K + 2);
  localparam int RING_W  = $clog2(MAX_K + 1);
  localparam int ADDR_W  = RING_W + 1;
  localparam int MEM_D   = 2 ** ADDR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KWANT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NPTS   = CFG_IDX_W'(2);

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  function automatic logic [CNT_W-1:0] eff_k(logic [NW_W-1:0] nw);
    logic [CNT_W-1:0] k;
    if (nw == '0) begin
      k = CNT_W'(1);
    end else if (32'(nw) > 32'(MAX_K)) begin
      k = CNT_W'(MAX_K);
    end else begin
      k = CNT_W'(nw);
    end
    return k;
  endfunction

  function automatic logic [BND_W-1:0] sentinel(logic [BND_W-1:0] n);
    logic [BND_W-1:0] c;
    c = (32'(n) > 32'(MAX_POINTS)) ? BND_W'(MAX_POINTS) : n;
    return c + BND_W'(1);
  endfunction

endpackage

// ===== rtl/rwnlb_if.sv =====
// Valid/ready channel interfaces for the neighbor list builder.
// Depends on rwnlb_pkg for field widths.
interface rwnlb_in_if;
  logic                         valid;
  logic                         ready;
  logic [rwnlb_pkg::IDX_W-1:0]  neighbor_index;

  modport source (output valid, output neighbor_index, input ready);
  modport sink   (input valid, input neighbor_index, output ready);
endinterface

interface rwnlb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         side;
  logic [rwnlb_pkg::BND_W-1:0]  bound_low;
  logic [rwnlb_pkg::BND_W-1:0]  bound_high;
  logic [rwnlb_pkg::BND_W-1:0]  member;
  logic                         last_member;

  modport source (output valid, output side, output bound_low, output bound_high,
                  output member, output last_member, input ready);
  modport sink   (input valid, input side, input bound_low, input bound_high,
                  input member, input last_member, output ready);
endinterface

// ===== rtl/range_window_neighbor_list_builder.sv =====
// Range window neighbor list builder: top level with list memory and control.
// Depends on rwnlb_pkg and the channel interfaces in rwnlb_if.sv.
//
// Both side lists live in one synchronous memory (one write port, one
// registered read port), the left list as a ring so that dropping its minimum
// only advances a base pointer. An item outside the window or equal to the
// center is taken in S_IDLE and dropped. An item that enters a list goes
// through the read-compare-write sweep of the memory (S_INS_RD, S_INS_CMP and,
// when it shifts past every entry, S_INS_PUT), shifting past at most k
// entries. An item that overfills a list passes through S_EVICT, then S_EMIT
// issues the first read and streams the k members of the record at one
// transaction per cycle when the sink is ready. After reset and after every
// configuration write to a defined register the block writes the list
// sentinels in S_INIT_L and S_INIT_R and accepts no item during that time.
module range_window_neighbor_list_builder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rwnlb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rwnlb_pkg::CFG_W-1:0]      cfg_wdata_i,
  rwnlb_in_if.sink                         nbr_i,
  rwnlb_out_if.source                      rec_o
);
  import rwnlb_pkg::*;

  localparam logic [2:0] S_INIT_L  = 3'd0;
  localparam logic [2:0] S_INIT_R  = 3'd1;
  localparam logic [2:0] S_IDLE    = 3'd2;
  localparam logic [2:0] S_INS_RD  = 3'd3;
  localparam logic [2:0] S_INS_CMP = 3'd4;
  localparam logic [2:0] S_INS_PUT = 3'd5;
  localparam logic [2:0] S_EVICT   = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [IDX_W-1:0]  center_q;
  logic [NW_W-1:0]   nw_q;
  logic [BND_W-1:0]  npts_q;
  logic              cfg_hit;

  logic [2:0]        state_q, state_d;
  logic              side_q, side_d;
  logic [BND_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  lcnt_q, lcnt_d;
  logic [CNT_W-1:0]  rcnt_q, rcnt_d;
  logic [RING_W-1:0] base_q, base_d;
  logic [BND_W-1:0]  floor_q, floor_d;
  logic [BND_W-1:0]  ceil_q, ceil_d;
  logic [BND_W-1:0]  ev_q, ev_d;
  logic [BND_W-1:0]  nmax_q, nmax_d;
  logic [CNT_W-1:0]  z_q, z_d;
  logic [CNT_W-1:0]  mz_q, mz_d;
  logic              rd_vld_q, rd_vld_d;

  logic              out_vld_q, out_vld_d;
  logic              out_side_q, out_side_d;
  logic [BND_W-1:0]  out_lo_q, out_lo_d;
  logic [BND_W-1:0]  out_hi_q, out_hi_d;
  logic [BND_W-1:0]  out_mem_q, out_mem_d;
  logic              out_last_q, out_last_d;

  logic [BND_W-1:0]  mem [MEM_D];
  logic [BND_W-1:0]  rdata_q;
  logic              we, ren, wside, issue, move, out_free, in_acc;
  logic [CNT_W-1:0]  widx, ridx, k, side_cnt;
  logic [BND_W-1:0]  wdata, nbr_ext;
  logic [RING_W-1:0] wring, rring;
  logic [ADDR_W-1:0] waddr, raddr;

  assign k        = eff_k(nw_q);
  assign cfg_hit  = cfg_we_i && (cfg_idx_i == CFG_CENTER || cfg_idx_i == CFG_KWANT ||
                                 cfg_idx_i == CFG_NPTS);
  assign nbr_ext  = {1'b0, nbr_i.neighbor_index};
  assign side_cnt = side_q ? rcnt_q : lcnt_q;
  assign out_free = !out_vld_q || rec_o.ready;
  assign in_acc   = nbr_i.valid && (state_q == S_IDLE);

  assign wring = wside ? widx[RING_W-1:0] : base_q + widx[RING_W-1:0];
  assign rring = side_q ? ridx[RING_W-1:0] : base_q + ridx[RING_W-1:0];
  assign waddr = {wside, wring};
  assign raddr = {side_q, rring};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      nw_q     <= NW_W'(1);
      npts_q   <= BND_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER: center_q <= cfg_wdata_i[IDX_W-1:0];
        CFG_KWANT:  nw_q     <= cfg_wdata_i[NW_W-1:0];
        CFG_NPTS:   npts_q   <= cfg_wdata_i[BND_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    val_d      = val_q;
    pos_d      = pos_q;
    lcnt_d     = lcnt_q;
    rcnt_d     = rcnt_q;
    base_d     = base_q;
    floor_d    = floor_q;
    ceil_d     = ceil_q;
    ev_d       = ev_q;
    nmax_d     = nmax_q;
    z_d        = z_q;
    mz_d       = mz_q;
    rd_vld_d   = rd_vld_q;
    out_vld_d  = out_vld_q;
    out_side_d = out_side_q;
    out_lo_d   = out_lo_q;
    out_hi_d   = out_hi_q;
    out_mem_d  = out_mem_q;
    out_last_d = out_last_q;
    we         = 1'b0;
    wside      = side_q;
    widx       = pos_q;
    wdata      = val_q;
    ren        = 1'b0;
    ridx       = pos_q - CNT_W'(1);
    issue      = 1'b0;
    move       = 1'b0;

    if (out_vld_q && rec_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_INIT_L: begin
        we      = 1'b1;
        wside   = SIDE_LEFT;
        widx    = '0;
        wdata   = '0;
        lcnt_d  = CNT_W'(1);
        floor_d = '0;
        state_d = S_INIT_R;
      end
      S_INIT_R: begin
        we      = 1'b1;
        wside   = SIDE_RIGHT;
        widx    = '0;
        wdata   = sentinel(npts_q);
        rcnt_d  = CNT_W'(1);
        ceil_d  = sentinel(npts_q);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          val_d = nbr_ext;
          if (nbr_i.neighbor_index < center_q && nbr_ext > floor_q) begin
            side_d  = SIDE_LEFT;
            pos_d   = lcnt_q;
            state_d = S_INS_RD;
          end else if (nbr_i.neighbor_index > center_q && nbr_ext < ceil_q) begin
            side_d  = SIDE_RIGHT;
            pos_d   = rcnt_q;
            state_d = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        ren     = 1'b1;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rdata_q > val_q) begin
          wdata = rdata_q;
          pos_d = pos_q - CNT_W'(1);
          if (pos_q == CNT_W'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            ren  = 1'b1;
            ridx = pos_q - CNT_W'(2);
          end
        end else begin
          state_d = (side_cnt == k) ? S_EVICT : S_IDLE;
          if (side_cnt != k) begin
            if (side_q) rcnt_d = rcnt_q + CNT_W'(1);
            else        lcnt_d = lcnt_q + CNT_W'(1);
          end
        end
      end
      S_INS_PUT: begin
        we      = 1'b1;
        state_d = (side_cnt == k) ? S_EVICT : S_IDLE;
        if (side_cnt != k) begin
          if (side_q) rcnt_d = rcnt_q + CNT_W'(1);
          else        lcnt_d = lcnt_q + CNT_W'(1);
        end
      end
      S_EVICT: begin
        if (side_q) begin
          ev_d   = ceil_q;
          ceil_d = nmax_q;
        end else begin
          ev_d   = floor_q;
          base_d = base_q + RING_W'(1);
        end
        z_d     = '0;
        mz_d    = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        move  = rd_vld_q && out_free;
        issue = (z_q < k) && (!rd_vld_q || move);
        ridx  = z_q;
        ren   = issue;
        if (issue) begin
          z_d = z_q + CNT_W'(1);
        end
        if (move) begin
          out_vld_d  = 1'b1;
          out_side_d = side_q;
          out_lo_d   = side_q ? ceil_q : ev_q;
          out_hi_d   = side_q ? ev_q : ((mz_q == '0) ? rdata_q : out_hi_q);
          out_mem_d  = rdata_q;
          out_last_d = (mz_q == k - CNT_W'(1));
          mz_d       = mz_q + CNT_W'(1);
          if (!side_q && mz_q == '0) begin
            floor_d = rdata_q;
          end
          if (mz_q == k - CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
        rd_vld_d = issue || (rd_vld_q && !move);
      end
      default: begin
        state_d = S_INIT_L;
      end
    endcase

    if (we && widx == k - CNT_W'(1)) begin
      nmax_d = wdata;
    end

    if (cfg_hit) begin
      state_d   = S_INIT_L;
      base_d    = '0;
      out_vld_d = 1'b0;
      rd_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT_L;
      lcnt_q    <= CNT_W'(1);
      rcnt_q    <= CNT_W'(1);
      base_q    <= '0;
      floor_q   <= '0;
      ceil_q    <= sentinel(BND_W'(1));
      z_q       <= '0;
      mz_q      <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lcnt_q    <= lcnt_d;
      rcnt_q    <= rcnt_d;
      base_q    <= base_d;
      floor_q   <= floor_d;
      ceil_q    <= ceil_d;
      z_q       <= z_d;
      mz_q      <= mz_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q     <= side_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    ev_q       <= ev_d;
    nmax_q     <= nmax_d;
    out_side_q <= out_side_d;
    out_lo_q   <= out_lo_d;
    out_hi_q   <= out_hi_d;
    out_mem_q  <= out_mem_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
    end
  end

  assign nbr_i.ready       = (state_q == S_IDLE);
  assign rec_o.valid       = out_vld_q;
  assign rec_o.side        = out_side_q;
  assign rec_o.bound_low   = out_lo_q;
  assign rec_o.bound_high  = out_hi_q;
  assign rec_o.member      = out_mem_q;
  assign rec_o.last_member = out_last_q;

endmodule

// ===== rtl/rwnlb_chk.sv =====
// Port-level checker for the range window neighbor list builder.
// Depends on rwnlb_pkg and the top level's ports; bound to the top level below.
module rwnlb_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [rwnlb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            out_last_i
);
  import rwnlb_pkg::*;

  logic cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_CENTER || cfg_idx_i == CFG_KWANT ||
                                cfg_idx_i == CFG_NPTS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !cfg_we_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> !in_ready_i)
    else $error("input ready right after a configuration write");

  a_rec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while a record is still streaming");

  a_rst_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input ready before sentinels are written");

endmodule

bind range_window_neighbor_list_builder rwnlb_chk u_rwnlb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_ready_i  (nbr_i.ready),
  .out_valid_i (rec_o.valid),
  .out_ready_i (rec_o.ready),
  .out_last_i  (rec_o.last_member)
);
